/* rtl/modinv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared types and defaults for the extended Euclid modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

    // Default datapath width; operands are DEFAULT_WIDTH-1 bits wide
    localparam int DEFAULT_WIDTH = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_NORM
    } modinv_state_t;

endpackage : modinv_pkg
`default_nettype wire

/* rtl/modular_inverse_extended_euclid_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Operation: from the accepting edge the sequencer runs E Euclid steps, E up to about 46
//   at WIDTH=32. Each step is a check state, a divider pass of W = WIDTH-1 quotient bits
//   and an update state; a final check and the normalization add/subtract states follow
//   before done rises.
// Throughput: one request at a time; busy drops as done rises, so the next start is taken then.
// Reset: rst_n clears the sequencer to idle and the done strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// modular_inverse_extended_euclid_top
// Extended Euclid on (A, B) tracking the Bezout coefficient of B, normalized by
// max(A, B). Division is done by one serial restoring divider that also builds
// q*cur with a shift-add accumulator.
// ----------------------------------------------------------------------------
module modular_inverse_extended_euclid_top
    import modinv_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [WIDTH-2:0] first_operand,
    input  wire logic [WIDTH-2:0] second_operand,
    output logic                  done,
    output logic [WIDTH-2:0]      inverse_coefficient
);

    localparam int OW    = WIDTH - 1;        // operand width
    localparam int CW    = WIDTH + 1;        // signed coefficient width
    localparam int CNT_W = $clog2(OW);

    modinv_state_t     state_reg, state_next;
    logic              done_reg, done_next;
    logic [OW-1:0]     a_reg, a_next;        // dividend, shifted out MSB first
    logic [OW-1:0]     b_reg, b_next;        // divisor
    logic [OW-1:0]     m_reg, m_next;        // max(A, B)
    logic [OW-1:0]     rem_reg, rem_next;    // partial remainder
    logic [CW-1:0]     prev_reg, prev_next;  // previous coefficient / normalized value
    logic [CW-1:0]     cur_reg, cur_next;    // current coefficient
    logic [CW-1:0]     acc_reg, acc_next;    // running q*cur
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OW-1:0]     res_reg, res_next;

    // Divider step
    logic [OW:0]       rem_sh;
    logic              ge;
    logic [OW:0]       rem_sub;
    logic [CW-1:0]     m_ext;

    assign rem_sh  = {rem_reg, a_reg[OW-1]};
    assign ge      = (rem_sh >= {1'b0, b_reg});
    assign rem_sub = rem_sh - {1'b0, b_reg};
    assign m_ext   = {2'b00, m_reg};

    assign busy                = (state_reg != ST_IDLE);
    assign done                = done_reg;
    assign inverse_coefficient = res_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        rem_next   = rem_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next     = first_operand;
                    b_next     = second_operand;
                    m_next     = (first_operand > second_operand) ? first_operand
                                                                  : second_operand;
                    prev_next  = '0;
                    cur_next   = CW'(1);
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (b_reg == '0)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(OW - 1);
                    state_next = ST_DIV;
                end
            end

            // one quotient bit per cycle; acc = 2*acc + qbit*cur
            ST_DIV:
            begin
                rem_next = ge ? rem_sub[OW-1:0] : rem_sh[OW-1:0];
                acc_next = {acc_reg[CW-2:0], 1'b0} + (ge ? cur_reg : '0);
                a_next   = {a_reg[OW-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end

            // (a, b, prev, cur) <- (b, r, cur, prev - q*cur)
            ST_UPDATE:
            begin
                a_next     = b_reg;
                b_next     = rem_reg;
                prev_next  = cur_reg;
                cur_next   = prev_reg - acc_reg;
                state_next = ST_CHECK;
            end

            // result zero if M is zero; else add M while negative, subtract while above M
            ST_NORM:
            begin
                if (m_reg == '0)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (prev_reg[CW-1])
                begin
                    prev_next = prev_reg + m_ext;
                end
                else if ($signed(prev_reg) > $signed(m_ext))
                begin
                    prev_next = prev_reg - m_ext;
                end
                else
                begin
                    res_next   = prev_reg[OW-1:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        m_reg    <= m_next;
        rem_reg  <= rem_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    // Checks
    a_done_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result strobe");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (b_reg != '0))
        else $error("divider running with zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < b_reg))
        else $error("partial remainder not below divisor");

endmodule : modular_inverse_extended_euclid_top
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the extended Euclid modular inverse block against an in-bench
// predictor of the normalized Bezout coefficient of the second operand.
// Directed corner requests come first, then random requests with and without
// idle gaps. Each request's result is compared in order on the done strobe.
// ----------------------------------------------------------------------------
module tb
    import modinv_pkg::*;
();

    localparam int OPW = DEFAULT_WIDTH - 1;
    localparam logic [OPW-1:0] OP_MAX = '1;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic [OPW-1:0] first_operand;
    logic [OPW-1:0] second_operand;
    logic           done;
    logic [OPW-1:0] inverse_coefficient;

    // Expected coefficients, oldest first
    logic [OPW-1:0] expected_mem [0:511];
    logic [8:0]     exp_wr_idx;
    logic [8:0]     exp_rd_idx;
    int             error_count;
    bit             gaps_enabled;

    modular_inverse_extended_euclid_top #(
        .WIDTH (DEFAULT_WIDTH)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .first_operand       (first_operand),
        .second_operand      (second_operand),
        .done                (done),
        .inverse_coefficient (inverse_coefficient)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // Coefficient of b from extended Euclid, two's complement in 64 bits,
    // then folded into 0..max(a,b); a value equal to the max is kept as is.
    function automatic logic [OPW-1:0] bezout_inverse(input logic [OPW-1:0] a_in,
                                                      input logic [OPW-1:0] b_in);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] prev;
        logic [63:0] cur;
        logic [63:0] nxt;
        logic [63:0] modulus;
        logic [63:0] mag;
        logic [63:0] folds;
        logic [63:0] norm;
        a       = 64'(a_in);
        b       = 64'(b_in);
        modulus = (a > b) ? a : b;
        prev    = 64'd0;
        cur     = 64'd1;
        while (b != 64'd0)
        begin
            quot = a / b;
            rem  = a - quot * b;
            nxt  = prev - quot * cur;
            a    = b;
            b    = rem;
            prev = cur;
            cur  = nxt;
        end
        if (modulus == 64'd0)
            norm = 64'd0;
        else if (prev[63])
        begin
            // negative: add the smallest multiple of M that lifts it to >= 0
            mag   = 64'd0 - prev;
            folds = mag / modulus + ((mag % modulus) != 64'd0 ? 64'd1 : 64'd0);
            norm  = folds * modulus - mag;
        end
        else if (prev > modulus)
            norm = (prev - 64'd1) % modulus + 64'd1;
        else
            norm = prev;
        return norm[OPW-1:0];
    endfunction

    // Idle length before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 5);
        else
            return $urandom_range(20, 2500);
    endfunction

    // Issue one request; returns at the falling edge after it was taken.
    // start stays high so a following request can go out without a gap.
    task automatic send_request(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
        int gap;
        gap = gaps_enabled ? pick_gap() : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          <= 1'b1;
        first_operand  <= a;
        second_operand <= b;
        // busy is stable at the falling edge; low here means taken next edge
        while (busy !== 1'b0)
            @(negedge clk);
        expected_mem[exp_wr_idx] = bezout_inverse(a, b);
        exp_wr_idx = exp_wr_idx + 9'd1;
        @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        logic [OPW-1:0] want;
        if (rst_n && done === 1'b1)
        begin
            if (exp_wr_idx == exp_rd_idx)
            begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, inverse_coefficient);
                error_count++;
            end
            else
            begin
                want = expected_mem[exp_rd_idx];
                exp_rd_idx = exp_rd_idx + 9'd1;
                if (inverse_coefficient !== want)
                begin
                    $display("%0t: inverse_coefficient mismatch, expected %0d, actual %0d",
                             $time, want, inverse_coefficient);
                    error_count++;
                end
            end
        end
    end

    // Field extremes and all-ones patterns
    task automatic test_operand_extremes();
        send_request(OP_MAX, OP_MAX);
        send_request(OP_MAX, 31'd1);
        send_request(31'd1, OP_MAX);
        send_request(OP_MAX, OP_MAX - 31'd1);
        send_request(31'h4000_0000, 31'h3fff_ffff);
        send_request(31'h5555_5555, 31'h2aaa_aaaa);
        send_request(31'h2aaa_aaab, 31'h5555_5555);
        // consecutive Fibonacci numbers: the longest Euclid chain in range
        send_request(31'd1836311903, 31'd1134903170);
    endtask

    // Cases named in the block's description
    task automatic test_special_cases();
        send_request(31'd0, 31'd0);         // both zero
        send_request(31'd17, 31'd0);        // B zero, loop skipped
        send_request(OP_MAX, 31'd0);
        send_request(31'd0, 31'd5);         // A zero
        send_request(31'd1, 31'd1);         // coefficient equals M
        send_request(31'd7, 31'd7);
        send_request(31'd5, 31'd13);        // A below B, pair swaps
        send_request(31'd12, 31'd18);       // not coprime
        send_request(31'd1000, 31'd250);    // B divides A
        send_request(31'd26, 31'd7);        // plain inverse
        send_request(31'd2147483629, 31'd65537);
        send_request(31'd2, 31'd1);
    endtask

    // Random pair drawn from one of several shapes
    task automatic random_pair(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        int          shape;
        logic [OPW-1:0] t;
        int unsigned g;
        shape = $urandom_range(0, 9);
        a = OPW'($urandom());
        b = OPW'($urandom());
        case (shape)
            0, 1, 2, 3, 4:
            begin
                // usual use: modulus above the value
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            5:
            begin
                // small operands
                a = OPW'($urandom_range(0, 255));
                b = OPW'($urandom_range(0, 255));
            end
            6:
            begin
                // common factor, not an inverse
                g = $urandom_range(2, 1000);
                a = OPW'(g * $urandom_range(0, 2147483));
                b = OPW'(g * $urandom_range(0, 2147483));
            end
            7:
            begin
                // one side tiny or zero
                if ($urandom_range(0, 1))
                    b = OPW'($urandom_range(0, 3));
                else
                    a = OPW'($urandom_range(0, 3));
            end
            default:
                ; // as drawn, either order
        endcase
    endtask

    // Random requests with idle gaps on the request side
    task automatic test_random_with_gaps(input int count);
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        gaps_enabled = 1'b1;
        repeat (count)
        begin
            random_pair(a, b);
            send_request(a, b);
        end
    endtask

    // Random requests with start held high throughout
    task automatic test_back_to_back(input int count);
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        gaps_enabled = 1'b0;
        repeat (count)
        begin
            random_pair(a, b);
            send_request(a, b);
        end
    endtask

    // Sequence
    initial
    begin
        error_count    = 0;
        exp_wr_idx     = '0;
        exp_rd_idx     = '0;
        gaps_enabled   = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        first_operand  = '0;
        second_operand = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_operand_extremes();
        test_special_cases();
        test_random_with_gaps(280);
        test_back_to_back(100);

        start <= 1'b0;
        while (exp_wr_idx != exp_rd_idx)
            @(posedge clk);
        // catch any stray strobe
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
